FILE: rtl/core/rabs_pkg.sv
// Shared constants, register indexes and types of the running-average background subtractor.
package rabs_pkg;

   localparam int MAX_PIXELS = 524288;
   localparam int IDX_W      = $clog2(MAX_PIXELS);
   localparam int FP_W       = 20;
   localparam int PIX_W      = 8;
   localparam int ALPHA_W    = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int GREY_W     = 24;
   localparam int GREY_SHIFT = 14;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
   localparam logic [13:0]        W_B       = 14'd1868;
   localparam logic [13:0]        W_G       = 14'd9617;
   localparam logic [13:0]        W_R       = 14'd4899;
   localparam logic [GREY_W-1:0]  GREY_RND  = GREY_W'(8192);
   localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN_RATE   = 3'd0,
      CSR_FG_THRESHOLD = 3'd1,
      CSR_THRESHOLD_ON = 3'd2,
      CSR_COLOR_MODE   = 3'd3,
      CSR_FRAME_PIXELS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
   } pix_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      pix_type          data;
   } bg_wr_type;

endpackage

FILE: rtl/core/rabs_if.sv
// Valid/ready channel interfaces for pixel requests and subtraction responses.
interface rabs_req_if;
   import rabs_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pix_b;
   logic [PIX_W-1:0] pix_g;
   logic [PIX_W-1:0] pix_r;

   modport source (output valid, output pix_b, output pix_g, output pix_r, input ready);
   modport sink (input valid, input pix_b, input pix_g, input pix_r, output ready);
endinterface

interface rabs_rsp_if;
   import rabs_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] fg_value;
   logic [PIX_W-1:0] bg_b;
   logic [PIX_W-1:0] bg_g;
   logic [PIX_W-1:0] bg_r;
   logic             frame_end;

   modport source (output valid, output fg_value, output bg_b, output bg_g, output bg_r,
                   output frame_end, input ready);
   modport sink (input valid, input fg_value, input bg_b, input bg_g, input bg_r,
                 input frame_end, output ready);
endinterface

FILE: rtl/core/rabs_bg_store.sv
// Background frame store: one write port and one registered read port.
module rabs_bg_store (
   input  logic                        clock,
   input  rabs_pkg::bg_wr_type         wr,
   input  logic                        rd_en,
   input  logic [rabs_pkg::IDX_W-1:0]  rd_addr,
   output rabs_pkg::pix_type           rd_data
);
   import rabs_pkg::*;

   pix_type mem [MAX_PIXELS];
   pix_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/running_average_background_subtract.sv
// Running-average background subtractor top level with a four-stage pixel pipeline.
//
// Pixels enter on the req_bus channel in raster order, one per transaction, and every
// transaction yields exactly one response transaction on rsp_bus: the foreground value,
// the updated background pixel and a frame_end flag on the last pixel of each frame.
// Users must write registers via csr_ port only while the block is idle; not enforced.
//
// A pixel accepted into stage A moves through stages B and C and is presented on
// rsp_bus from stage D. One pixel is accepted in every cycle while rsp_bus is not
// stalled; the rate is set by the background store's one read port and one write
// port, with the pixel's read at acceptance and its write one stage later, and a
// same-address bypass covering back-to-back hits.
//
// Reset clears the pipeline, the pixel index and the registers to their defaults and
// marks the next frame as the first one, during which each pixel becomes its own
// background. The store itself is not cleared.
//
// When the receiver holds rsp_bus.ready low, the output stage holds its transaction and
// the stages behind it keep filling, so up to three further requests are accepted.
module running_average_background_subtract (
   input  logic                             clock,
   input  logic                             reset,
   rabs_req_if.sink                         req_bus,
   rabs_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [rabs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rabs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rabs_pkg::*;

   function automatic logic [PIX_W-1:0] abs_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [PIX_W-1:0] blend(logic [ALPHA_W-1:0] alpha,
                                              logic [PIX_W-1:0] pin,
                                              logic [PIX_W-1:0] bg);
      logic signed [PIX_W:0]    d;
      logic signed [26:0]       prod;
      logic signed [27:0]       acc;
      d    = $signed({1'b0, pin}) - $signed({1'b0, bg});
      prod = 27'($signed({1'b0, alpha})) * 27'(d);
      acc  = $signed({4'b0, bg, 16'b0}) + 28'(prod) + 28'sd32768;
      return acc[23:16];
   endfunction

   logic [ALPHA_W-1:0] learn_rate_ff;
   logic [PIX_W-1:0]   fg_threshold_ff;
   logic               threshold_on_ff;
   logic               color_mode_ff;
   logic [FP_W-1:0]    frame_pixels_ff;

   logic [IDX_W-1:0]   pixel_index_ff, pixel_index_in;
   logic               first_frame_ff, first_frame_in;

   logic               a_valid_ff, a_valid_in;
   pix_type            a_pix_ff, a_pix_in;
   logic [IDX_W-1:0]   a_idx_ff;
   logic               a_first_ff;
   logic               a_last_ff, a_last_in;
   logic               a_byp_ff, a_byp_in;
   pix_type            a_byp_data_ff;

   logic               b_valid_ff, b_valid_in;
   pix_type            b_diff_ff, b_diff_in;
   pix_type            b_bg_ff, b_bg_in;
   logic               b_last_ff;

   logic               c_valid_ff, c_valid_in;
   logic [PIX_W-1:0]   c_grey_ff, c_grey_in;
   pix_type            c_bg_ff;
   logic               c_last_ff;

   logic               d_valid_ff, d_valid_in;
   logic [PIX_W-1:0]   d_fg_ff, d_fg_in;
   pix_type            d_bg_ff;
   logic               d_last_ff;

   logic               en_a, en_b, en_c, en_d, accept;
   logic [FP_W-1:0]    fp_eff, idx_next;
   logic [ALPHA_W-1:0] alpha_eff;
   pix_type            mem_rd, bg_mem, bg_sel;
   bg_wr_type          bg_wr;
   logic [GREY_W-1:0]  grey_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff   <= ALPHA_W'(3277);
         fg_threshold_ff <= 8'd15;
         threshold_on_ff <= 1'b1;
         color_mode_ff   <= 1'b0;
         frame_pixels_ff <= FP_W'(307200);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEARN_RATE:   learn_rate_ff   <= csr_data[ALPHA_W-1:0];
            CSR_FG_THRESHOLD: fg_threshold_ff <= csr_data[PIX_W-1:0];
            CSR_THRESHOLD_ON: threshold_on_ff <= csr_data[0];
            CSR_COLOR_MODE:   color_mode_ff   <= csr_data[0];
            CSR_FRAME_PIXELS: frame_pixels_ff <= csr_data[FP_W-1:0];
            default: ;
         endcase
      end
   end

   assign alpha_eff = (learn_rate_ff > ALPHA_ONE) ? ALPHA_ONE : learn_rate_ff;

   always_comb begin
      if (frame_pixels_ff == '0) begin
         fp_eff = FP_W'(1);
      end else if (frame_pixels_ff > FP_W'(MAX_PIXELS)) begin
         fp_eff = FP_W'(MAX_PIXELS);
      end else begin
         fp_eff = frame_pixels_ff;
      end
   end

   assign en_d   = !d_valid_ff || rsp_bus.ready;
   assign en_c   = !c_valid_ff || en_d;
   assign en_b   = !b_valid_ff || en_c;
   assign en_a   = !a_valid_ff || en_b;
   assign accept = req_bus.valid && en_a;
   assign req_bus.ready = en_a;

   assign idx_next  = {1'b0, pixel_index_ff} + FP_W'(1);
   assign a_last_in = (idx_next >= fp_eff);

   always_comb begin
      pixel_index_in = pixel_index_ff;
      first_frame_in = first_frame_ff;
      if (accept) begin
         pixel_index_in = a_last_in ? '0 : idx_next[IDX_W-1:0];
         if (a_last_in) begin
            first_frame_in = 1'b0;
         end
      end
   end

   always_comb begin
      a_pix_in.b = req_bus.pix_b;
      a_pix_in.g = color_mode_ff ? req_bus.pix_g : '0;
      a_pix_in.r = color_mode_ff ? req_bus.pix_r : '0;
   end

   // The item leaving stage A writes the store at the same edge a new item reads it.
   assign a_byp_in = a_valid_ff && en_b && (a_idx_ff == pixel_index_ff);

   assign bg_mem = a_byp_ff ? a_byp_data_ff : mem_rd;

   always_comb begin
      if (a_first_ff) begin
         bg_sel = a_pix_ff;
      end else begin
         bg_sel.b = bg_mem.b;
         bg_sel.g = color_mode_ff ? bg_mem.g : '0;
         bg_sel.r = color_mode_ff ? bg_mem.r : '0;
      end
      b_diff_in.b = abs_diff(a_pix_ff.b, bg_sel.b);
      b_diff_in.g = abs_diff(a_pix_ff.g, bg_sel.g);
      b_diff_in.r = abs_diff(a_pix_ff.r, bg_sel.r);
      b_bg_in.b   = blend(alpha_eff, a_pix_ff.b, bg_sel.b);
      b_bg_in.g   = blend(alpha_eff, a_pix_ff.g, bg_sel.g);
      b_bg_in.r   = blend(alpha_eff, a_pix_ff.r, bg_sel.r);
   end

   assign bg_wr.en   = a_valid_ff && en_b;
   assign bg_wr.addr = a_idx_ff;
   assign bg_wr.data = b_bg_in;

   rabs_bg_store u_bg_store (
      .clock   (clock),
      .wr      (bg_wr),
      .rd_en   (accept),
      .rd_addr (pixel_index_ff),
      .rd_data (mem_rd)
   );

   assign grey_sum = GREY_W'(W_B) * GREY_W'(b_diff_ff.b) +
                     GREY_W'(W_G) * GREY_W'(b_diff_ff.g) +
                     GREY_W'(W_R) * GREY_W'(b_diff_ff.r) + GREY_RND;

   always_comb begin
      if (!color_mode_ff) begin
         c_grey_in = b_diff_ff.b;
      end else if (grey_sum[GREY_W-1:GREY_SHIFT] > (GREY_W-GREY_SHIFT)'(PIX_MAX)) begin
         c_grey_in = PIX_MAX;
      end else begin
         c_grey_in = grey_sum[GREY_SHIFT+PIX_W-1:GREY_SHIFT];
      end
   end

   always_comb begin
      if (threshold_on_ff) begin
         d_fg_in = (c_grey_ff > fg_threshold_ff) ? PIX_MAX : '0;
      end else begin
         d_fg_in = c_grey_ff;
      end
   end

   assign a_valid_in = en_a ? req_bus.valid : a_valid_ff;
   assign b_valid_in = en_b ? a_valid_ff : b_valid_ff;
   assign c_valid_in = en_c ? b_valid_ff : c_valid_ff;
   assign d_valid_in = en_d ? c_valid_ff : d_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_index_ff <= '0;
         first_frame_ff <= 1'b1;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         d_valid_ff     <= 1'b0;
      end else begin
         pixel_index_ff <= pixel_index_in;
         first_frame_ff <= first_frame_in;
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= b_valid_in;
         c_valid_ff     <= c_valid_in;
         d_valid_ff     <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff      <= a_pix_in;
         a_idx_ff      <= pixel_index_ff;
         a_first_ff    <= first_frame_ff;
         a_last_ff     <= a_last_in;
         a_byp_ff      <= a_byp_in;
         a_byp_data_ff <= b_bg_in;
      end
      if (en_b) begin
         b_diff_ff <= b_diff_in;
         b_bg_ff   <= b_bg_in;
         b_last_ff <= a_last_ff;
      end
      if (en_c) begin
         c_grey_ff <= c_grey_in;
         c_bg_ff   <= b_bg_ff;
         c_last_ff <= b_last_ff;
      end
      if (en_d) begin
         d_fg_ff   <= d_fg_in;
         d_bg_ff   <= c_bg_ff;
         d_last_ff <= c_last_ff;
      end
   end

   assign rsp_bus.valid     = d_valid_ff;
   assign rsp_bus.fg_value  = d_fg_ff;
   assign rsp_bus.bg_b      = d_bg_ff.b;
   assign rsp_bus.bg_g      = d_bg_ff.g;
   assign rsp_bus.bg_r      = d_bg_ff.r;
   assign rsp_bus.frame_end = d_last_ff;

endmodule
